// ----- rtl/core/mpm_pkg.sv -----
// Shared types and constants for the 2x2 modular matrix power block.
package mpm_pkg;

    localparam int ENTRY_W = 16;
    localparam int EXP_W   = 31;
    localparam int RED_W   = 2 * ENTRY_W + 1;
    localparam int CNT_W   = $clog2(RED_W + 1);

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_a;
        logic [ENTRY_W-1:0] entry_b;
        logic [ENTRY_W-1:0] entry_c;
        logic [ENTRY_W-1:0] entry_d;
        logic [EXP_W-1:0]   exponent;
        logic [ENTRY_W-1:0] modulus;
    } t_in;

    typedef struct packed {
        logic [ENTRY_W-1:0] result_a;
        logic [ENTRY_W-1:0] result_b;
        logic [ENTRY_W-1:0] result_c;
        logic [ENTRY_W-1:0] result_d;
        logic               modulus_error;
    } t_out;

    typedef enum logic [1:0] {
        K_IDENT,
        K_MODERR,
        K_POWER
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_in   item;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_HEAD,
        S_SHIFT,
        S_MUL1,
        S_MUL2,
        S_DONE
    } t_bstate;

endpackage

// ----- rtl/core/matrix_power_mod_2x2.sv -----
// Top level of the 2x2 modular matrix power block.
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//
// Work: a zero exponent or a zero modulus is answered straight from the queue.
//   Otherwise each entry of a matrix product is two passes through the one
//   multiplier and a bit-serial reduction of the 33-bit sum by the modulus.
// Reset: synchronous, active low; clears handshake and sequencer state.
// Stalls: a two-entry queue decouples the front end from the sequencer;
//   a finished result waits in the output register.
module matrix_power_mod_2x2 import mpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // front -> queue
    logic   w_push;
    t_job   w_fjob;
    // queue -> back
    t_job   w_qjob;
    t_qstat w_qstat;
    logic   w_pop;

    mpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_job      (w_fjob)
    );

    mpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_qstat (w_qstat)
    );

    // sequencer: one transaction in flight at a time
    mpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_qjob),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.modulus_error |->
            o_out_data.result_a == '0 && o_out_data.result_b == '0 &&
            o_out_data.result_c == '0 && o_out_data.result_d == '0)
        else $error("error result carries nonzero entries");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/core/mpm_front.sv -----
// Front end: takes input transactions and classifies them into jobs.
module mpm_front import mpm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_in    i_in_data,
    input  t_qstat i_qstat,
    output logic   o_push,
    output t_job   o_job
);

    logic r_valid;
    t_job r_job;
    logic w_accept;

    assign o_push     = r_valid && !i_qstat.full;
    assign o_in_stall = r_valid && i_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_job      = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.item <= i_in_data;
            priority if (i_in_data.exponent == '0) begin
                r_job.kind <= K_IDENT;
            end else if (i_in_data.modulus == '0) begin
                r_job.kind <= K_MODERR;
            end else begin
                r_job.kind <= K_POWER;
            end
        end
    end

endmodule

// ----- rtl/core/mpm_queue.sv -----
// Two-entry job queue between front and back.
module mpm_queue import mpm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);
    assign o_job         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ----- rtl/core/mpm_back.sv -----
// Back end: square-and-multiply sequencer with one multiplier and a serial reducer.
module mpm_back import mpm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  t_qstat i_qstat,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_out   o_out_data
);

    t_bstate r_state, n_state;

    logic [3:0][ENTRY_W-1:0] r_acc;
    logic [3:0][ENTRY_W-1:0] r_base;
    logic [3:0][ENTRY_W-1:0] r_prod;
    logic [ENTRY_W-1:0]      r_mod;
    logic [EXP_W-1:0]        r_n;
    logic [1:0]              r_idx;
    logic                    r_op;   // 0: acc*base, 1: base*base
    logic                    r_init; // reducing the raw base entries
    logic [RED_W-1:0]        r_sh;
    logic [ENTRY_W-1:0]      r_rem;
    logic [CNT_W-1:0]        r_cnt;
    t_out                    r_out;
    logic                    r_ovalid;

    logic                 w_free;
    logic                 w_last;
    logic [ENTRY_W:0]     w_trial;
    logic [ENTRY_W-1:0]   w_rem;
    logic [ENTRY_W-1:0]   w_x1, w_x2, w_y1, w_y2, w_mx, w_my;
    logic [2*ENTRY_W-1:0] w_mul;
    logic [1:0]           w_nidx;

    assign w_free      = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign w_nidx      = r_idx + 2'd1;

    // one restoring step per cycle, MSB first
    assign w_trial = {r_rem, r_sh[RED_W-1]};
    always_comb begin
        if (w_trial >= {1'b0, r_mod}) begin
            w_rem = ENTRY_W'(w_trial - {1'b0, r_mod});
        end else begin
            w_rem = w_trial[ENTRY_W-1:0];
        end
    end
    assign w_last = (r_cnt == CNT_W'(RED_W - 1));

    // operand select for entry (i, j) = (idx[1], idx[0])
    assign w_x1 = r_op ? r_base[{r_idx[1], 1'b0}] : r_acc[{r_idx[1], 1'b0}];
    assign w_x2 = r_op ? r_base[{r_idx[1], 1'b1}] : r_acc[{r_idx[1], 1'b1}];
    assign w_y1 = r_base[{1'b0, r_idx[0]}];
    assign w_y2 = r_base[{1'b1, r_idx[0]}];
    assign w_mx = (r_state == S_MUL2) ? w_x2 : w_x1;
    assign w_my = (r_state == S_MUL2) ? w_y2 : w_y1;
    assign w_mul = {{ENTRY_W{1'b0}}, w_mx} * {{ENTRY_W{1'b0}}, w_my};

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty && (i_job.kind == K_POWER || w_free)) begin
                    o_pop = 1'b1;
                    if (i_job.kind == K_POWER) n_state = S_RED;
                end
            end
            S_RED: begin
                if (w_last) begin
                    if (r_init) begin
                        if (r_idx == 2'd3) n_state = S_HEAD;
                    end else if (r_idx == 2'd3) begin
                        n_state = r_op ? S_HEAD : S_SHIFT;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_HEAD:  n_state = r_n[0] ? S_MUL1 : S_SHIFT;
            S_SHIFT: n_state = (r_n[EXP_W-1:1] != '0) ? S_MUL1 : S_DONE;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_RED;
            S_DONE:  if (w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((o_pop && i_job.kind != K_POWER) || (r_state == S_DONE && w_free)) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    unique case (i_job.kind)
                        K_IDENT:  r_out <= '{ENTRY_W'(1), '0, '0, ENTRY_W'(1), 1'b0};
                        K_MODERR: r_out <= '{'0, '0, '0, '0, 1'b1};
                        default: begin
                            r_base <= {i_job.item.entry_d, i_job.item.entry_c,
                                       i_job.item.entry_b, i_job.item.entry_a};
                            r_mod  <= i_job.item.modulus;
                            r_n    <= i_job.item.exponent;
                            r_acc[0] <= (i_job.item.modulus == ENTRY_W'(1)) ? '0 : ENTRY_W'(1);
                            r_acc[1] <= '0;
                            r_acc[2] <= '0;
                            r_acc[3] <= (i_job.item.modulus == ENTRY_W'(1)) ? '0 : ENTRY_W'(1);
                            r_init <= 1'b1;
                            r_idx  <= 2'd0;
                            r_sh   <= RED_W'(i_job.item.entry_a);
                            r_rem  <= '0;
                            r_cnt  <= '0;
                        end
                    endcase
                end
            end
            S_RED: begin
                // next raw entry starts a fresh reduction; otherwise keep shifting
                if (w_last && r_init && r_idx != 2'd3) begin
                    r_sh  <= RED_W'(r_base[w_nidx]);
                    r_rem <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sh  <= {r_sh[RED_W-2:0], 1'b0};
                    r_rem <= w_rem;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (w_last) begin
                    r_idx <= w_nidx;
                    if (r_init) begin
                        r_base[r_idx] <= w_rem;
                        if (r_idx == 2'd3) begin
                            r_init <= 1'b0;
                        end
                    end else begin
                        r_prod[r_idx] <= w_rem;
                        if (r_idx == 2'd3) begin
                            if (r_op) begin
                                r_base <= {w_rem, r_prod[2], r_prod[1], r_prod[0]};
                            end else begin
                                r_acc  <= {w_rem, r_prod[2], r_prod[1], r_prod[0]};
                            end
                        end
                    end
                end
            end
            S_HEAD: begin
                r_op  <= 1'b0;
                r_idx <= 2'd0;
            end
            S_SHIFT: begin
                r_n   <= r_n >> 1;
                r_op  <= 1'b1;
                r_idx <= 2'd0;
            end
            S_MUL1: r_sh <= RED_W'(w_mul);
            S_MUL2: begin
                r_sh  <= r_sh + RED_W'(w_mul);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DONE: begin
                if (w_free) r_out <= '{r_acc[0], r_acc[1], r_acc[2], r_acc[3], 1'b0};
            end
            default: ;
        endcase
    end

endmodule

// ----- bench/matrix_power_mod_2x2_test.sv -----
// Self-checking testbench for the 2x2 modular matrix power block.
module matrix_power_mod_2x2_test;
    import mpm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    matrix_power_mod_2x2 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Work queued for the driver, and results still owed by the block.
    t_in  pending_jobs[$];
    t_out owed_results[$];

    int  mismatch_count = 0;
    int  matrices_sent  = 0;
    int  results_seen   = 0;
    int  errors_seen    = 0;
    int  idents_seen    = 0;
    int  idle_cycles    = 0;
    bit  calm_mode      = 1'b0;   // no random idling on either side
    bit  hold_receiver  = 1'b0;   // long receiver hold-off in progress
    bit  pause_sender   = 1'b0;   // sender waits for a drained block
    bit  in_taken       = 1'b0;   // input transaction accepted at the last rising edge

    // ------------------------------------------------------------------
    // Predictor: square-and-multiply with exact wide products.
    // ------------------------------------------------------------------
    function automatic t_out matrix_power(t_in job);
        t_out               res;
        logic [63:0]        m;
        logic [63:0]        base[4];
        logic [63:0]        acc[4];
        logic [63:0]        tmp[4];
        logic [EXP_W-1:0]   n;
        res = '0;
        n   = job.exponent;
        m   = 64'(job.modulus);
        if (n == 0) begin
            res.result_a = ENTRY_W'(1);
            res.result_d = ENTRY_W'(1);
            return res;
        end
        if (m == 0) begin
            res.modulus_error = 1'b1;
            return res;
        end
        base[0] = job.entry_a % m;
        base[1] = job.entry_b % m;
        base[2] = job.entry_c % m;
        base[3] = job.entry_d % m;
        acc[0]  = 1 % m;
        acc[1]  = 0;
        acc[2]  = 0;
        acc[3]  = 1 % m;
        while (n != 0) begin
            if (n[0]) begin
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        tmp[i*2+j] = ((acc[i*2] * base[j]) % m
                                      + (acc[i*2+1] * base[2+j]) % m) % m;
                acc = tmp;
            end
            n = n >> 1;
            if (n != 0) begin
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        tmp[i*2+j] = ((base[i*2] * base[j]) % m
                                      + (base[i*2+1] * base[2+j]) % m) % m;
                base = tmp;
            end
        end
        res.result_a = acc[0][ENTRY_W-1:0];
        res.result_b = acc[1][ENTRY_W-1:0];
        res.result_c = acc[2][ENTRY_W-1:0];
        res.result_d = acc[3][ENTRY_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
    endtask

    // Remember whether the offered item went in at the rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
    end

    // ------------------------------------------------------------------
    // Driver: takes the next job at the falling edge once the previous
    // transaction has gone; valid stays up between back-to-back items.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (i_in_valid && !in_taken) begin
            // held: payload must not move
        end else if (pending_jobs.size() != 0 && !pause_sender
                     && (calm_mode || $urandom_range(99) >= 16)) begin
            i_in_valid <= 1'b1;
            i_in_data  <= pending_jobs.pop_front();
        end else begin
            i_in_valid <= 1'b0;
            i_in_data  <= t_in'({$urandom, $urandom, $urandom, $urandom});
        end
    end

    // Receiver stall: random, quiet in calm mode, solid during hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else if (hold_receiver)
            i_out_stall <= 1'b1;
        else if (calm_mode)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < 16);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input, check on accepted output.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                owed_results.push_back(matrix_power(i_in_data));
                matrices_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    t_out want;
                    want = owed_results.pop_front();
                    if (o_out_data.result_a !== want.result_a)
                        report_mismatch("result_a", 32'(o_out_data.result_a),
                                        32'(want.result_a));
                    if (o_out_data.result_b !== want.result_b)
                        report_mismatch("result_b", 32'(o_out_data.result_b),
                                        32'(want.result_b));
                    if (o_out_data.result_c !== want.result_c)
                        report_mismatch("result_c", 32'(o_out_data.result_c),
                                        32'(want.result_c));
                    if (o_out_data.result_d !== want.result_d)
                        report_mismatch("result_d", 32'(o_out_data.result_d),
                                        32'(want.result_d));
                    if (o_out_data.modulus_error !== want.modulus_error)
                        report_mismatch("modulus_error", 32'(o_out_data.modulus_error),
                                        32'(want.modulus_error));
                    if (want.modulus_error)
                        errors_seen++;
                end
            end
        end
    end

    // Watchdog: cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", owed_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Job builders: small exponents mostly, a few full-width ones.
    function automatic t_in job_of(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                   logic [15:0] d, logic [EXP_W-1:0] e, logic [15:0] m);
        t_in j;
        j.entry_a  = a;
        j.entry_b  = b;
        j.entry_c  = c;
        j.entry_d  = d;
        j.exponent = e;
        j.modulus  = m;
        return j;
    endfunction

    function automatic t_in random_job();
        t_in         j;
        int unsigned pick;
        j    = t_in'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 60)
            j.exponent = EXP_W'($urandom_range(15));
        else if (pick < 85)
            j.exponent = EXP_W'($urandom_range(255));
        else if (pick < 95)
            j.exponent = EXP_W'($urandom & ((1 << $urandom_range(EXP_W)) - 1));
        // remaining few keep a full-width exponent
        pick = $urandom_range(99);
        if (pick < 5)
            j.modulus = '0;
        else if (pick < 10)
            j.modulus = ENTRY_W'(1);
        else if (pick < 20)
            j.modulus = ENTRY_W'($urandom_range(16, 2));
        return j;
    endfunction

    task automatic wait_drained();
        while (pending_jobs.size() != 0 || owed_results.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: identity cases, zero modulus, modulus one, extremes.
        pending_jobs.push_back(job_of(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 0, 0));
        pending_jobs.push_back(job_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 1));
        pending_jobs.push_back(job_of(16'h0001, 16'h0002, 16'h0003, 16'h0004, 0, 16'hffff));
        pending_jobs.push_back(job_of(16'h0001, 16'h0002, 16'h0003, 16'h0004, 5, 0));
        pending_jobs.push_back(job_of(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                      31'h7fffffff, 0));
        pending_jobs.push_back(job_of(16'h0007, 16'h0003, 16'h0002, 16'h0009, 3, 1));
        pending_jobs.push_back(job_of(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                      31'h7fffffff, 1));
        pending_jobs.push_back(job_of(16'h0001, 16'h0001, 16'h0001, 16'h0000, 1, 16'hffff));
        pending_jobs.push_back(job_of(16'h0001, 16'h0001, 16'h0001, 16'h0000, 30, 16'hffff));
        pending_jobs.push_back(job_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 16'hffff));
        pending_jobs.push_back(job_of(16'hffff, 16'hfffe, 16'hfffd, 16'hfffc,
                                      31'h7fffffff, 16'hfffb));
        pending_jobs.push_back(job_of(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                      31'h40000000, 16'hfff1));
        pending_jobs.push_back(job_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 2, 16'h8000));
        pending_jobs.push_back(job_of(16'h0002, 16'h0000, 16'h0000, 16'h0003, 16, 2));
        pending_jobs.push_back(job_of(16'hffff, 16'h0000, 16'h0000, 16'hffff, 2, 16'hffff));
        pending_jobs.push_back(job_of(16'haaaa, 16'h5555, 16'h5555, 16'haaaa,
                                      31'h55555555, 16'haaab));
        pending_jobs.push_back(job_of(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                                      31'h2aaaaaaa, 16'h5555));
        // calm stretch for the directed part
        calm_mode = 1'b1;
        wait_drained();
        calm_mode = 1'b0;

        // Long receiver hold-off while the sender keeps offering jobs.
        for (int k = 0; k < 8; k++)
            pending_jobs.push_back(random_job());
        hold_receiver = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_receiver = 1'b0;

        // Random traffic, with one sender pause until fully drained.
        for (int k = 0; k < 1000; k++) begin
            if (k == 400) begin
                pause_sender = 1'b1;
                while (owed_results.size() != 0 || i_in_valid)
                    @(posedge i_clk);
                pause_sender = 1'b0;
            end
            if (k == 600)
                calm_mode = 1'b1;
            if (k == 750)
                calm_mode = 1'b0;
            pending_jobs.push_back(random_job());
            while (pending_jobs.size() > 4)
                @(posedge i_clk);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("%0d matrices sent, %0d results checked (%0d flagged zero modulus)",
                 matrices_sent, results_seen, errors_seen);
        $display("identity, zero/one modulus, full-width exponents, stalls and hold-offs");
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     owed_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
